### hdl/sfr_pkg.sv
// Package for the serial flash reader: item codes, flash opcodes, sequencer codes,
// field widths and the word types carried on the request and response channels.
// No dependencies.
`default_nettype none

package sfr_pkg;

	localparam int STORE_BYTES_DEF = 262144;
	localparam int CMD_W           = 2;
	localparam int BYTE_W          = 8;
	localparam int LOAD_ADDR_W     = 18;
	localparam int CNT_W           = 3;

	localparam logic [CMD_W-1:0] ITEM_XFER  = 2'd0;
	localparam logic [CMD_W-1:0] ITEM_DESEL = 2'd1;
	localparam logic [CMD_W-1:0] ITEM_LOAD  = 2'd2;

	localparam logic [BYTE_W-1:0] OP_READ = 8'h03;
	localparam logic [BYTE_W-1:0] OP_WRDI = 8'h04;
	localparam logic [BYTE_W-1:0] OP_RDSR = 8'h05;
	localparam logic [BYTE_W-1:0] OP_WREN = 8'h06;

	localparam logic [1:0] ACT_IDLE   = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_STATUS = 2'd2;

	localparam logic [CNT_W-1:0] CNT_SAT = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]       cmd;
		logic [BYTE_W-1:0]      data_byte;
		logic [LOAD_ADDR_W-1:0] load_address;
	} req_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] reply_byte;
		logic              bad_command;
	} rsp_word_t;

endpackage

`default_nettype wire

### hdl/sfr_if.sv
// Valid/ready channel interfaces for the serial flash reader.
// Depends on sfr_pkg for the word types.
`default_nettype none

interface sfr_req_if
	import sfr_pkg::*;
;
	logic      valid;
	logic      ready;
	req_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sfr_rsp_if
	import sfr_pkg::*;
;
	logic      valid;
	logic      ready;
	rsp_word_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/sfr_store.sv
// Flash byte store: one write port, one read port with registered read data.
// Depends on sfr_pkg for the byte width.
`default_nettype none

module sfr_store
	import sfr_pkg::*;
#(
	parameter int ADDR_W = 18
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [BYTE_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [2**ADDR_W];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### hdl/spi_serial_flash_reader_unit.sv
// Serial flash reader: request words pass registers s1 then s2 to become response words.
// One word per cycle unless rsp stalls; the single store read port serves a byte a cycle.
// Reset clears command, pointer, byte count, write enable and both pipeline stages at once;
// the store is not cleared and holds whatever was loaded. STORE_BYTES must be a power of two,
// which the block does not enforce. Depends on sfr_pkg, sfr_if and sfr_store.
`default_nettype none

module spi_serial_flash_reader_unit
	import sfr_pkg::*;
#(
	parameter int STORE_BYTES = STORE_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sfr_req_if.sink   req,
	sfr_rsp_if.source rsp
);

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int EXT_W  = (ADDR_W > LOAD_ADDR_W) ? ADDR_W : LOAD_ADDR_W;

	logic [1:0]        act_q, act_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
	logic              we_q, we_d;

	logic [BYTE_W-1:0]   reply_c;
	logic                bad_c;
	logic                rd_c;
	logic                wr_c;
	logic [ADDR_W+7:0]   ptr_shifted;
	logic [EXT_W-1:0]    load_ext;

	logic              accept;
	logic              adv_s1;
	logic              valid_s1, valid_s2;
	logic [BYTE_W-1:0] reply_s1, reply_s2;
	logic              bad_s1, bad_s2;
	logic              from_mem_s1;
	logic [BYTE_W-1:0] mem_rd_data;

	assign adv_s1    = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	assign ptr_shifted = {ptr_q, req.payload.data_byte};
	assign load_ext    = EXT_W'(req.payload.load_address);
	assign cnt_inc     = (cnt_q < CNT_SAT) ? cnt_q + 3'd1 : cnt_q;

	always_comb begin
		act_d   = act_q;
		ptr_d   = ptr_q;
		cnt_d   = cnt_q;
		we_d    = we_q;
		reply_c = '0;
		bad_c   = 1'b0;
		rd_c    = 1'b0;
		wr_c    = 1'b0;
		unique case (req.payload.cmd)
			ITEM_XFER: begin
				cnt_d   = cnt_inc;
				reply_c = req.payload.data_byte;
				unique case (act_q)
					ACT_READ: begin
						if (cnt_inc < CNT_SAT) begin
							ptr_d = ptr_shifted[ADDR_W-1:0];
						end else begin
							rd_c  = 1'b1;
							ptr_d = ptr_q + ADDR_W'(1);
						end
					end
					ACT_STATUS: begin
						reply_c = {{(BYTE_W-1){1'b0}}, we_q};
					end
					default: begin
						unique case (req.payload.data_byte)
							OP_READ: act_d = ACT_READ;
							OP_WRDI: we_d  = 1'b0;
							OP_RDSR: act_d = ACT_STATUS;
							OP_WREN: we_d  = 1'b1;
							default: bad_c = 1'b1;
						endcase
					end
				endcase
			end
			ITEM_DESEL: begin
				act_d = ACT_IDLE;
				ptr_d = '0;
				cnt_d = '0;
			end
			ITEM_LOAD: begin
				wr_c = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACT_IDLE;
			ptr_q <= '0;
			cnt_q <= '0;
			we_q  <= 1'b0;
		end else if (accept) begin
			act_q <= act_d;
			ptr_q <= ptr_d;
			cnt_q <= cnt_d;
			we_q  <= we_d;
		end
	end

	sfr_store #(
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (accept && wr_c),
		.wr_addr (load_ext[ADDR_W-1:0]),
		.wr_data (req.payload.data_byte),
		.rd_en   (accept && rd_c),
		.rd_addr (ptr_q),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			reply_s1    <= reply_c;
			bad_s1      <= bad_c;
			from_mem_s1 <= rd_c;
		end
		if (adv_s1 && valid_s1) begin
			reply_s2 <= from_mem_s1 ? mem_rd_data : reply_s1;
			bad_s2   <= bad_s1;
		end
	end

	assign rsp.valid               = valid_s2;
	assign rsp.payload.reply_byte  = reply_s2;
	assign rsp.payload.bad_command = bad_s2;

endmodule

`default_nettype wire

### hdl/sfr_checker.sv
// Port-level checks for the serial flash reader, bound to the top level.
// Depends on sfr_pkg for opcodes and spi_serial_flash_reader_unit for the bind.
`default_nettype none

module sfr_checker
	import sfr_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic [BYTE_W-1:0] rsp_reply_byte,
	input wire logic              rsp_bad_command
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reply_byte)
			&& $stable(rsp_bad_command))
		else $error("response word changed while stalled");

	a_bad_not_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_bad_command |-> rsp_reply_byte != OP_READ
			&& rsp_reply_byte != OP_WRDI && rsp_reply_byte != OP_RDSR
			&& rsp_reply_byte != OP_WREN)
		else $error("known opcode flagged as bad");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request blocked with empty output");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("response valid during reset");

endmodule

bind spi_serial_flash_reader_unit sfr_checker u_sfr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_reply_byte  (rsp.payload.reply_byte),
	.rsp_bad_command (rsp.payload.bad_command)
);

`default_nettype wire

### verif/spi_serial_flash_reader_unit_checker.sv
// Checker for the serial flash reader: watches both channels, tracks the flash state
// on every accepted request word and compares each response word with the reply due.
// Depends on sfr_pkg and sfr_if.
`timescale 1ns / 1ps

module spi_serial_flash_reader_unit_checker
	import sfr_pkg::*;
#(
	parameter int STORE_BYTES = STORE_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sfr_req_if   req,
	sfr_rsp_if   rsp,
	output int   errors,
	output int   pending
);

	logic [BYTE_W-1:0] flash_image [STORE_BYTES];
	logic [1:0]        mode;
	int unsigned       read_ptr;
	logic [CNT_W-1:0]  link_count;
	logic              write_en;
	rsp_word_t         replies_due [$];

	function automatic int unsigned wrap_pos(input longint unsigned a);
		return int'(a % STORE_BYTES);
	endfunction

	function automatic rsp_word_t serve_word(input req_word_t w);
		rsp_word_t r;
		r = '0;
		case (w.cmd)
			ITEM_XFER: begin
				r.reply_byte = w.data_byte;
				if (link_count < CNT_SAT)
					link_count = link_count + 1'b1;
				if (mode == ACT_READ) begin
					if (link_count < CNT_SAT) begin
						read_ptr = wrap_pos((longint'(read_ptr) << BYTE_W) | w.data_byte);
					end else begin
						r.reply_byte = flash_image[read_ptr];
						read_ptr = wrap_pos(longint'(read_ptr) + 1);
					end
				end else if (mode == ACT_STATUS) begin
					r.reply_byte = {{(BYTE_W-1){1'b0}}, write_en};
				end else begin
					case (w.data_byte)
						OP_READ: mode = ACT_READ;
						OP_WRDI: write_en = 1'b0;
						OP_RDSR: mode = ACT_STATUS;
						OP_WREN: write_en = 1'b1;
						default: r.bad_command = 1'b1;
					endcase
				end
			end
			ITEM_DESEL: begin
				mode = ACT_IDLE;
				read_ptr = 0;
				link_count = '0;
			end
			ITEM_LOAD: flash_image[wrap_pos(w.load_address)] = w.data_byte;
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t due;
		if (!arst_n) begin
			mode = ACT_IDLE;
			read_ptr = 0;
			link_count = '0;
			write_en = 1'b0;
			replies_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected word: expected none, actual byte %02h flag %0b",
						$time, rsp.payload.reply_byte, rsp.payload.bad_command);
				end else begin
					due = replies_due.pop_front();
					if (rsp.payload.reply_byte !== due.reply_byte) begin
						errors++;
						$display("%0t: reply_byte expected %02h actual %02h",
							$time, due.reply_byte, rsp.payload.reply_byte);
					end
					if (rsp.payload.bad_command !== due.bad_command) begin
						errors++;
						$display("%0t: bad_command expected %0b actual %0b",
							$time, due.bad_command, rsp.payload.bad_command);
					end
				end
			end
			if (req.valid && req.ready)
				replies_due.push_back(serve_word(req.payload));
			pending = replies_due.size();
		end
	end

endmodule

### verif/spi_serial_flash_reader_unit_tb.sv
// Testbench top for the serial flash reader: clock, reset, request stimulus and response
// back-pressure, with the checker beside the block giving the verdict count.
// Depends on sfr_pkg, sfr_if, the block and spi_serial_flash_reader_unit_checker.
`timescale 1ns / 1ps

module spi_serial_flash_reader_unit_tb;
	import sfr_pkg::*;

	localparam logic [CMD_W-1:0] ITEM_NONE = 2'd3;
	localparam int RANDOM_ITEMS    = 800;
	localparam int RSP_HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES   = 10;
	localparam int LIMIT_CYCLES    = 3000000;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	bit   hold_rsp_req;
	bit   no_gap;
	int   issued;

	logic [1:0]       link_mode;
	int unsigned      link_ptr;
	logic [CNT_W-1:0] link_count;
	bit               loaded [STORE_BYTES_DEF];

	sfr_req_if req_ch ();
	sfr_rsp_if rsp_ch ();

	spi_serial_flash_reader_unit uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	spi_serial_flash_reader_unit_checker #(.STORE_BYTES(STORE_BYTES_DEF)) chk (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.errors (errors),
		.pending(pending)
	);

	always #5 clk = ~clk;

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("simulation failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_word(input req_word_t w);
		int gap;
		gap = no_gap ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= w;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic issue(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] d,
			input logic [LOAD_ADDR_W-1:0] a);
		req_word_t w;
		// fill the byte a stream transfer is about to fetch
		if (c == ITEM_XFER && link_mode == ACT_READ && link_count >= CNT_SAT - 1'b1
				&& !loaded[link_ptr]) begin
			w = '{cmd: ITEM_LOAD, data_byte: BYTE_W'($urandom()),
				load_address: LOAD_ADDR_W'(link_ptr)};
			send_word(w);
			loaded[link_ptr] = 1'b1;
			issued++;
		end
		w = '{cmd: c, data_byte: d, load_address: a};
		send_word(w);
		if (c != ITEM_NONE)
			issued++;
		case (c)
			ITEM_XFER: begin
				if (link_count < CNT_SAT)
					link_count = link_count + 1'b1;
				if (link_mode == ACT_READ) begin
					if (link_count < CNT_SAT)
						link_ptr = ((link_ptr << BYTE_W) | d) % STORE_BYTES_DEF;
					else
						link_ptr = (link_ptr + 1) % STORE_BYTES_DEF;
				end else if (link_mode == ACT_IDLE && d == OP_READ) begin
					link_mode = ACT_READ;
				end else if (link_mode == ACT_IDLE && d == OP_RDSR) begin
					link_mode = ACT_STATUS;
				end
			end
			ITEM_DESEL: begin
				link_mode = ACT_IDLE;
				link_ptr = 0;
				link_count = '0;
			end
			ITEM_LOAD: loaded[a] = 1'b1;
			default: ;
		endcase
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// response side back-pressure
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rsp_req) begin
				hold_rsp_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat (($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 6)) @(posedge clk);
				stall = pick_gap();
				if (stall > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int kind;
		int n;
		int next_drain;
		int unsigned base;
		bit flooded;
		bit flooding;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		link_mode = ACT_IDLE;
		link_ptr = 0;
		link_count = '0;
		issued = 0;
		flooded = 1'b0;
		flooding = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(ITEM_XFER, 8'h00, '0);
		issue(ITEM_XFER, 8'hFF, '1);
		issue(ITEM_XFER, OP_WREN, '0);
		issue(ITEM_XFER, OP_RDSR, '0);
		issue(ITEM_XFER, 8'hAA, '0);
		issue(ITEM_XFER, 8'h55, '1);
		issue(ITEM_DESEL, 8'hFF, '1);
		issue(ITEM_XFER, OP_WRDI, '0);
		issue(ITEM_XFER, OP_RDSR, '0);
		issue(ITEM_XFER, 8'hFF, '0);
		issue(ITEM_DESEL, 8'h00, '0);
		issue(ITEM_NONE, 8'hFF, '1);
		issue(ITEM_LOAD, 8'hA5, '1);
		issue(ITEM_LOAD, 8'h5A, '0);
		issue(ITEM_LOAD, 8'hFF, 18'h3FFFE);
		issue(ITEM_LOAD, 8'h00, 18'h00001);
		issue(ITEM_XFER, OP_READ, '0);
		issue(ITEM_XFER, 8'hFF, '0);
		issue(ITEM_XFER, 8'hFF, '0);
		issue(ITEM_XFER, 8'hFE, '0);
		repeat (4) issue(ITEM_XFER, 8'h3C, '0);
		issue(ITEM_DESEL, 8'h00, '0);
		drain();

		issued = 0;
		next_drain = 200;
		while (issued < RANDOM_ITEMS) begin
			if (issued >= next_drain) begin
				drain();
				next_drain += 200;
			end
			no_gap = ($urandom_range(0, 9) == 0);
			kind = $urandom_range(0, 99);
			if (!flooded && issued >= 300) begin
				flooded = 1'b1;
				flooding = 1'b1;
				hold_rsp_req = 1'b1;
				no_gap = 1'b1;
				kind = 0;
			end
			if (kind < 50) begin
				if (flooding)
					n = 64;
				else if ($urandom_range(0, 9) == 0)
					n = $urandom_range(16, 40);
				else
					n = $urandom_range(1, 8);
				if ($urandom_range(0, 4) == 0)
					base = STORE_BYTES_DEF - 1 - $urandom_range(0, 5);
				else
					base = $urandom_range(0, STORE_BYTES_DEF - 1);
				if ($urandom_range(0, 9) < 7)
					for (int i = 0; i < n; i++)
						issue(ITEM_LOAD, BYTE_W'($urandom()),
							LOAD_ADDR_W'((base + i) % STORE_BYTES_DEF));
				issue(ITEM_XFER, OP_READ, LOAD_ADDR_W'($urandom()));
				issue(ITEM_XFER, {6'($urandom()), base[17:16]}, LOAD_ADDR_W'($urandom()));
				issue(ITEM_XFER, base[15:8], LOAD_ADDR_W'($urandom()));
				issue(ITEM_XFER, base[7:0], LOAD_ADDR_W'($urandom()));
				for (int i = 0; i < n; i++)
					issue(ITEM_XFER, BYTE_W'($urandom()), LOAD_ADDR_W'($urandom()));
				if ($urandom_range(0, 9) != 0)
					issue(ITEM_DESEL, BYTE_W'($urandom()), LOAD_ADDR_W'($urandom()));
				flooding = 1'b0;
			end else if (kind < 62) begin
				issue(ITEM_XFER, OP_RDSR, LOAD_ADDR_W'($urandom()));
				repeat ($urandom_range(1, 6))
					issue(ITEM_XFER, BYTE_W'($urandom()), LOAD_ADDR_W'($urandom()));
				if ($urandom_range(0, 9) != 0)
					issue(ITEM_DESEL, BYTE_W'($urandom()), LOAD_ADDR_W'($urandom()));
			end else if (kind < 77) begin
				repeat ($urandom_range(1, 3))
					issue(ITEM_XFER, $urandom_range(0, 1) ? OP_WREN : OP_WRDI,
						LOAD_ADDR_W'($urandom()));
				if ($urandom_range(0, 1))
					issue(ITEM_DESEL, BYTE_W'($urandom()), LOAD_ADDR_W'($urandom()));
			end else if (kind < 87) begin
				issue(ITEM_XFER, OP_READ, LOAD_ADDR_W'($urandom()));
				repeat ($urandom_range(0, 2))
					issue(ITEM_XFER, BYTE_W'($urandom()), LOAD_ADDR_W'($urandom()));
				issue(ITEM_DESEL, BYTE_W'($urandom()), LOAD_ADDR_W'($urandom()));
			end else begin
				repeat ($urandom_range(1, 4))
					issue(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom()),
						LOAD_ADDR_W'($urandom()));
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
hdl/sfr_pkg.sv
hdl/sfr_if.sv
hdl/sfr_store.sv
hdl/spi_serial_flash_reader_unit.sv
hdl/sfr_checker.sv
verif/spi_serial_flash_reader_unit_checker.sv
verif/spi_serial_flash_reader_unit_tb.sv
